// ----- rtl/core/olisd_pkg.sv -----
// types and codes shared by the ordered list blocks
package olisd_pkg;

  // command codes carried by an input item
  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_SEARCH    = 2'd2,
    CMD_DELETE    = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               full_res;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

// ----- rtl/core/olisd_store.sv -----
// entry store: one write port, one read port with registered read data
module olisd_store #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [olisd_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [olisd_pkg::WORD_W-1:0] rdata
);
  import olisd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ordered_list_insert_search_delete.sv -----
// insert front, insert back and a refused insert on a full list: any store write is made as the item is taken
// search: one stored entry read and compared per cycle, from the front until a match or the end of the list
// delete: scan as search, then one read and one write per entry behind the match
// the entry store has a single read port; one item is in work at a time,
// and the next item is taken in the cycle its predecessor's result appears
// reset clears the entry count and sequencer; the store itself is not cleared
module ordered_list_insert_search_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  olisd_pkg::in_item_t  cmd_item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output olisd_pkg::out_item_t res_item
);
  import olisd_pkg::*;

  localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [LEN_W-1:0]   length, length_next;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]   cmp_ptr, cmp_ptr_next;
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [LEN_W-1:0]   cnt, cnt_next;
  logic               pend, pend_next;
  logic [WORD_W-1:0]  key, key_next;
  cmd_t               op, op_next;
  logic               found, found_next;
  logic               full, full_next;
  logic               res_valid_next;
  out_item_t          res_item_next;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;

  logic [LEN_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_dec;
  logic               accept;
  logic               match;
  logic [LEN_W+COUNT_W-1:0] count_ext;

  // pointer step forward with wrap at the end of the store
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  olisd_store #(
    .DEPTH (CAPACITY),
    .ADDR_W(PTR_W)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_ptr),
    .rdata(mem_rdata)
  );

  // physical slot behind the last entry, and the slot before the front
  assign tail_sum = (LEN_W + 1)'(head) + (LEN_W + 1)'(length);
  assign tail     = (tail_sum >= (LEN_W + 1)'(CAPACITY)) ?
                    PTR_W'(tail_sum - (LEN_W + 1)'(CAPACITY)) : PTR_W'(tail_sum);
  assign head_dec = (head == '0) ? PTR_W'(CAPACITY - 1) : head - PTR_W'(1);

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign match     = pend && (mem_rdata == key);
  assign count_ext = {{COUNT_W{1'b0}}, length};

  // sequencer: next state, store access and result
  always_comb begin
    state_next     = state;
    length_next    = length;
    head_next      = head;
    rd_ptr_next    = rd_ptr;
    cmp_ptr_next   = cmp_ptr;
    wr_ptr_next    = wr_ptr;
    cnt_next       = cnt;
    pend_next      = pend;
    key_next       = key;
    op_next        = op;
    found_next     = found;
    full_next      = full;
    res_valid_next = res_valid && res_stall;
    res_item_next  = res_item;
    mem_we         = 1'b0;
    mem_waddr      = tail;
    mem_wdata      = cmd_item.word;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          key_next   = cmd_item.word;
          op_next    = cmd_item.cmd;
          found_next = 1'b0;
          full_next  = 1'b0;
          unique case (cmd_item.cmd)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (length == LEN_W'(CAPACITY)) begin
                full_next = 1'b1;
              end else begin
                mem_we      = 1'b1;
                length_next = length + LEN_W'(1);
                if (cmd_item.cmd == CMD_INS_FRONT) begin
                  mem_waddr = head_dec;
                  head_next = head_dec;
                end
              end
              state_next = ST_DONE;
            end
            CMD_SEARCH, CMD_DELETE: begin
              rd_ptr_next = head;
              cnt_next    = '0;
              pend_next   = 1'b0;
              state_next  = ST_SCAN;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      // issue one read and compare the previous one each cycle
      ST_SCAN: begin
        if (match) begin
          found_next = 1'b1;
          pend_next  = 1'b0;
          if (op == CMD_DELETE) begin
            wr_ptr_next = cmp_ptr;
            cnt_next    = length - cnt;
            state_next  = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end else if (cnt != length) begin
          cmp_ptr_next = rd_ptr;
          rd_ptr_next  = ptr_inc(rd_ptr);
          cnt_next     = cnt + LEN_W'(1);
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = ST_DONE;
          end
        end
      end

      // move each entry behind the match one slot toward the front
      ST_SHIFT: begin
        if (pend) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr;
          mem_wdata   = mem_rdata;
          wr_ptr_next = ptr_inc(wr_ptr);
        end
        if (cnt != '0) begin
          rd_ptr_next = ptr_inc(rd_ptr);
          cnt_next    = cnt - LEN_W'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            length_next = length - LEN_W'(1);
            state_next  = ST_DONE;
          end
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          res_valid_next            = 1'b1;
          res_item_next.found       = found;
          res_item_next.full_res    = full;
          res_item_next.entry_count = count_ext[COUNT_W-1:0];
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      head      <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      head      <= head_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    cmp_ptr  <= cmp_ptr_next;
    wr_ptr   <= wr_ptr_next;
    cnt      <= cnt_next;
    key      <= key_next;
    op       <= op_next;
    found    <= found_next;
    full     <= full_next;
    res_item <= res_item_next;
  end

  // the list never holds more than its capacity
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a result never reports both a match and a refused insert
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_item.found && res_item.full_res))
    else $error("found and full both set");

  // an accepted item stalls the input, so the next one waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("second item taken while busy");

  // a delete that matched shortens the list by one
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && state_next == ST_DONE) |=> length == $past(length) - LEN_W'(1))
    else $error("delete did not shorten the list");

endmodule

// ----- verif/tb.sv -----
// testbench for the ordered list block: command stimulus, list tracker and result checks
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olisd_pkg::*;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_CMDS   = 450;
  localparam int unsigned SETTLE      = 2 * LIST_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // mixes of commands for the random part
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_EVEN,
    MIX_DRAIN
  } mix_t;

  // tracks the list contents and the results still owed by the block
  class list_scoreboard;
    logic [WORD_W-1:0] held_words[LIST_DEPTH];
    int unsigned       held_len = 0;
    out_item_t         awaited[$];
    int unsigned       mismatches = 0;

    function int find_word(logic [WORD_W-1:0] w);
      int unsigned i;
      for (i = 0; i < held_len; i++) begin
        if (held_words[i] == w) return int'(i);
      end
      return -1;
    endfunction

    // apply an accepted command to the list and queue its result
    function void note_cmd(in_item_t it);
      out_item_t   r;
      int          pos;
      int unsigned i;
      r = '0;
      case (it.cmd)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (held_len >= LIST_DEPTH) begin
            r.full_res = 1'b1;
          end else if (it.cmd == CMD_INS_FRONT) begin
            for (i = held_len; i > 0; i--) held_words[i] = held_words[i-1];
            held_words[0] = it.word;
            held_len++;
          end else begin
            held_words[held_len] = it.word;
            held_len++;
          end
        end
        CMD_SEARCH: begin
          r.found = (find_word(it.word) >= 0);
        end
        default: begin
          pos = find_word(it.word);
          if (pos >= 0) begin
            r.found = 1'b1;
            // close up behind the removed entry
            for (i = unsigned'(pos); i + 1 < held_len; i++) held_words[i] = held_words[i+1];
            held_len--;
          end
        end
      endcase
      r.entry_count = COUNT_W'(held_len);
      awaited.push_back(r);
    endfunction

    // compare a result item with the oldest one owed
    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result item with nothing owed: found %0d full_res %0d entry_count %0d",
               got.found, got.full_res, got.entry_count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.full_res !== want.full_res) begin
        $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_item_t  cmd_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  list_scoreboard    tracker = new();
  bit                hold_off_req = 1'b0;
  int unsigned       cycle_count = 0;
  logic [WORD_W-1:0] word_pool[8];

  ordered_list_insert_search_delete #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_result(res_item);
  end

  // receiver stalls: short bursts, a few long ones, quiet stretches and one long hold-off
  initial begin : res_stall_gen
    int unsigned run_left;
    int unsigned quiet_left;
    int unsigned r;
    run_left   = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (run_left != 0) begin
        run_left--;
        res_stall <= 1'b1;
      end else if (quiet_left != 0) begin
        quiet_left--;
        res_stall <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          res_stall <= 1'b0;
        end else if (r < 85) begin
          res_stall <= 1'b1;
          run_left = $urandom_range(2);
        end else if (r < 93) begin
          res_stall <= 1'b1;
          run_left = $urandom_range(40, 8);
        end else begin
          res_stall <= 1'b0;
          quiet_left = $urandom_range(120, 30);
        end
      end
    end
  end

  function automatic in_item_t make_item(cmd_t c, logic [WORD_W-1:0] w);
    in_item_t it;
    it.cmd  = c;
    it.word = w;
    return it;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // word for a search or delete: often one held in the list, else from the pool or random
  function automatic logic [WORD_W-1:0] pick_word(bit lookup);
    int unsigned r;
    r = $urandom_range(99);
    if (lookup && tracker.held_len != 0 && r < 50)
      return tracker.held_words[$urandom_range(tracker.held_len - 1)];
    if (r < 85) return word_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd(mix_t mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return (r < 35) ? CMD_INS_FRONT : (r < 70) ? CMD_INS_BACK :
                        (r < 85) ? CMD_SEARCH : CMD_DELETE;
      MIX_DRAIN: return (r < 10) ? CMD_INS_FRONT : (r < 20) ? CMD_INS_BACK :
                        (r < 40) ? CMD_SEARCH : CMD_DELETE;
      default:   return cmd_t'(r % 4);
    endcase
  endfunction

  // offer one command item and wait until it is taken
  task automatic send_cmd(input in_item_t it, input int unsigned gap);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    do @(posedge clk); while (cmd_stall);
    tracker.note_cmd(it);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned n;
    int unsigned no_gap_left;
    mix_t        mix;
    cmd_t        c;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, duplicates, misses, fill and refused inserts
    send_cmd(make_item(CMD_SEARCH,    32'h0000_0000), 0);
    send_cmd(make_item(CMD_DELETE,    32'hFFFF_FFFF), pick_gap());
    send_cmd(make_item(CMD_INS_FRONT, 32'h0000_0000), 0);
    send_cmd(make_item(CMD_INS_BACK,  32'hFFFF_FFFF), pick_gap());
    send_cmd(make_item(CMD_INS_FRONT, 32'h0000_0000), 0);
    send_cmd(make_item(CMD_SEARCH,    32'hFFFF_FFFF), 0);
    send_cmd(make_item(CMD_SEARCH,    32'hA5A5_A5A5), pick_gap());
    send_cmd(make_item(CMD_DELETE,    32'h0000_0000), 0);
    send_cmd(make_item(CMD_DELETE,    32'h5A5A_5A5A), 0);
    for (k = 0; k < LIST_DEPTH - 2; k++) begin
      send_cmd(make_item(k[0] ? CMD_INS_BACK : CMD_INS_FRONT,
                         k[0] ? ~(32'h1 << (2 * k)) : (32'h3 << (2 * k))), pick_gap());
    end
    send_cmd(make_item(CMD_INS_FRONT, 32'h1234_5678), 0);
    send_cmd(make_item(CMD_INS_BACK,  32'h8765_4321), 0);

    // random part in stretches of differing command mixes
    mix         = MIX_EVEN;
    no_gap_left = 0;
    for (n = 0; n < RAND_CMDS; n++) begin
      if (n % 40 == 0) begin
        mix = mix_t'($urandom_range(2));
        for (k = 0; k < 8; k++) word_pool[k] = $urandom;
        if ($urandom_range(2) == 0) no_gap_left = 30;
      end
      if (n == 120) hold_off_req = 1'b1;
      if (n == 300) drain_results();
      c = pick_cmd(mix);
      send_cmd(make_item(c, pick_word(c == CMD_SEARCH || c == CMD_DELETE)),
               (no_gap_left != 0) ? 0 : pick_gap());
      if (no_gap_left != 0) no_gap_left--;
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- ordered_list_insert_search_delete.f -----
rtl/core/olisd_pkg.sv
rtl/core/olisd_store.sv
rtl/core/ordered_list_insert_search_delete.sv
verif/tb.sv
